// ===== design/drhfs_pkg.sv =====
// ----------------------------------------------------------------------------
// drhfs_pkg
// Shared types and constants of the row-hit-first DRAM scheduler.
// ----------------------------------------------------------------------------
package drhfs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumBanks   = 8;
  localparam int unsigned RowBits    = 16;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned QidxBits   = $clog2(QueueDepth);
  localparam int unsigned BankBits   = 3;
  localparam int unsigned BidxBits   = (NumBanks > 1) ? $clog2(NumBanks) : 1;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDatBits = 8;

  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgDivider = 3'd0,
    CfgCcd     = 3'd1,
    CfgRp      = 3'd2,
    CfgRas     = 3'd3,
    CfgRcd     = 3'd4,
    CfgCl      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ClsHit      = 2'd0,
    ClsMiss     = 2'd1,
    ClsConflict = 2'd2
  } access_class_e;

  typedef enum logic {
    KindIssued   = 1'b0,
    KindRejected = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    BkIdle   = 2'd0,
    BkPick   = 2'd1,
    BkIssue  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic                func;
    logic [BankBits-1:0] req_bank;
    logic [RowBits-1:0]  req_row;
    logic [7:0]          req_tag;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [7:0]          out_tag;
    logic [BankBits-1:0] out_bank;
    logic [RowBits-1:0]  out_row;
    logic [1:0]          access_class;
    time_t               ready_cycle;
  } out_item_t;

  typedef struct packed {
    logic [4:0] divider;
    logic [7:0] ccd;
    logic [7:0] rp;
    logic [7:0] ras;
    logic [7:0] rcd;
    logic [7:0] cl;
  } cfg_t;

  typedef struct packed {
    logic [BankBits-1:0] bank;
    logic [RowBits-1:0]  row;
    logic [7:0]          tag;
  } entry_t;

  typedef struct packed {
    logic   tick;
    logic   enq;
    entry_t entry;
  } cmd_t;

endpackage

// ===== design/drhfs_if.sv =====
// ----------------------------------------------------------------------------
// drhfs_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
interface drhfs_in_if;
  import drhfs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drhfs_out_if;
  import drhfs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drhfs_cfg_if;
  import drhfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [CfgDatBits-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/drhfs_front.sv =====
// ----------------------------------------------------------------------------
// drhfs_front
// Accepts items, keeps the occupancy count, rejects full enqueues, and
// passes ticks and accepted enqueues to the command queue.
// ----------------------------------------------------------------------------
module drhfs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  drhfs_pkg::in_item_t           in_data_i,
  input  logic                          cq_ready_i,
  output logic                          cq_valid_o,
  output drhfs_pkg::cmd_t               cq_data_o,
  input  logic                          dec_i,
  output logic                          rej_valid_o,
  output logic [7:0]                    rej_tag_o,
  input  logic                          rej_ready_i
);
  import drhfs_pkg::*;

  logic [QidxBits:0] cnt_q, cnt_d;
  logic              full, fire, rej;

  assign full        = (cnt_q == (QidxBits+1)'(QueueDepth));
  assign rej         = in_data_i.func & full;
  assign in_ready_o  = rej ? rej_ready_i : cq_ready_i;
  assign fire        = in_valid_i & in_ready_o;
  assign rej_valid_o = in_valid_i & rej & cq_ready_i;
  assign rej_tag_o   = in_data_i.req_tag;
  assign cq_valid_o  = in_valid_i & ~rej & cq_ready_i;
  assign cq_data_o.tick  = ~in_data_i.func;
  assign cq_data_o.enq   = in_data_i.func;
  assign cq_data_o.entry = '{bank: in_data_i.req_bank, row: in_data_i.req_row,
                             tag: in_data_i.req_tag};

  always_comb begin
    cnt_d = cnt_q;
    if (fire && in_data_i.func && !full) cnt_d = cnt_d + 1'b1;
    if (dec_i) cnt_d = cnt_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QidxBits+1)'(QueueDepth)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rej_valid_o && cq_valid_o)) else $error("item sent twice");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_i |-> cnt_q != '0) else $error("count underflow");

endmodule

// ===== design/drhfs_cmdq.sv =====
// ----------------------------------------------------------------------------
// drhfs_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module drhfs_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  drhfs_pkg::cmd_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output drhfs_pkg::cmd_t rd_data_o
);
  import drhfs_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i & wr_ready_o;
  assign rd = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count invalid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("pointer mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("pointer mismatch");

endmodule

// ===== design/drhfs_back.sv =====
// ----------------------------------------------------------------------------
// drhfs_back
// Request queue, bank state and timers; picks and issues on ticks.
// ----------------------------------------------------------------------------
module drhfs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drhfs_pkg::cfg_t      cfg_i,
  input  logic                 cq_valid_i,
  output logic                 cq_ready_o,
  input  drhfs_pkg::cmd_t      cq_data_i,
  output logic                 dec_o,
  output logic                 iss_valid_o,
  output drhfs_pkg::out_item_t iss_data_o,
  input  logic                 iss_ready_i
);
  import drhfs_pkg::*;

  back_state_e st_q, st_d;
  logic [QueueDepth-1:0] qv_q;
  entry_t                qe_q [QueueDepth];
  logic [RowBits-1:0]    orow_q [NumBanks];
  logic [NumBanks-1:0]   open_q;
  time_t                 brdy_q [NumBanks];
  time_t                 bcf_q [NumBanks];
  time_t                 cyc_q, chan_q;
  logic [3:0]            ph_q;
  logic [4:0]            div;

  logic [QidxBits-1:0]   sel_q;
  logic [1:0]            cls_q;
  logic                  ok_q;
  out_item_t             res_q;
  logic                  res_v_q;

  logic [QueueDepth-1:0] rdy, hit, cand;
  logic [1:0]            cls [QueueDepth];
  logic [QidxBits-1:0]   wslot, psel;
  logic                  pok, hfound, cfound, boundary;
  logic [9:0]            dcl;
  logic [9:0]            dly;
  logic [14:0]           ccd_t, dly_t, ras_t, cl_t;
  entry_t                se;
  logic [BidxBits-1:0]   sb;

  always_comb begin
    div = cfg_i.divider;
    if (div == 5'd0) div = 5'd1;
    else if (div > 5'd16) div = 5'd16;
  end

  assign boundary = (ph_q == 4'd0) && (chan_q <= cyc_q);

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      logic [BidxBits-1:0] b;
      b = BidxBits'(qe_q[i].bank);
      rdy[i] = qv_q[i] && (brdy_q[b] <= cyc_q);
      if (!open_q[b]) cls[i] = ClsMiss;
      else if (orow_q[b] == qe_q[i].row) cls[i] = ClsHit;
      else cls[i] = ClsConflict;
      hit[i]  = rdy[i] && (cls[i] == ClsHit);
      cand[i] = rdy[i] && !((cls[i] == ClsConflict) && (bcf_q[b] > cyc_q));
    end
  end

  always_comb begin
    hfound = 1'b0;
    cfound = 1'b0;
    psel = '0;
    wslot = QidxBits'(QueueDepth - 1);
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hfound = 1'b1;
        psel = QidxBits'(i);
      end
      if (!qv_q[i]) wslot = QidxBits'(i);
    end
    if (!hfound) begin
      for (int i = QueueDepth - 1; i >= 0; i--) begin
        if (cand[i]) begin
          cfound = 1'b1;
          psel = QidxBits'(i);
        end
      end
    end
    pok = hfound | cfound;
  end

  assign se = qe_q[sel_q];
  assign sb = BidxBits'(se.bank);

  always_comb begin
    dly = 10'd0;
    dcl = 10'd0;
    if (cls_q == ClsConflict) dly = {2'b0, cfg_i.rp};
    dcl = dly + {2'b0, cfg_i.ras};
    if (cls_q != ClsHit) dly = dly + {2'b0, cfg_i.rcd};
    dly = dly + {2'b0, cfg_i.ccd};
    ccd_t = {7'b0, cfg_i.ccd} * {10'b0, div};
    dly_t = {5'b0, dly} * {10'b0, div};
    ras_t = {5'b0, dcl} * {10'b0, div};
    cl_t  = {5'b0, dly + {2'b0, cfg_i.cl}} * {10'b0, div};
  end

  assign cq_ready_o  = (st_q == BkIdle) && !res_v_q;
  assign iss_valid_o = res_v_q;
  assign iss_data_o  = res_q;
  assign dec_o       = (st_q == BkIssue) && ok_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle:  if (cq_valid_i && cq_ready_o && cq_data_i.tick) st_d = BkPick;
      BkPick:  st_d = BkIssue;
      BkIssue: st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BkIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BkPick) begin
      sel_q <= psel;
      cls_q <= cls[psel];
    end
    if (st_q == BkIdle && cq_valid_i && cq_ready_o && cq_data_i.enq)
      qe_q[wslot] <= cq_data_i.entry;
    if (dec_o) begin
      for (int i = 0; i < QueueDepth - 1; i++)
        if (i >= sel_q) qe_q[i] <= qe_q[i+1];
      res_q.result_kind  <= KindIssued;
      res_q.out_tag      <= se.tag;
      res_q.out_bank     <= se.bank;
      res_q.out_row      <= se.row;
      res_q.access_class <= cls_q;
      res_q.ready_cycle  <= cyc_q + time_t'(cl_t);
      orow_q[sb]         <= se.row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= '0;
      open_q <= '0;
      cyc_q <= '0;
      chan_q <= '0;
      ph_q <= '0;
      ok_q <= 1'b0;
      res_v_q <= 1'b0;
      for (int i = 0; i < NumBanks; i++) begin
        brdy_q[i] <= '0;
        bcf_q[i] <= '0;
      end
    end else begin
      if (iss_valid_o && iss_ready_i) res_v_q <= 1'b0;
      if (st_q == BkIdle && cq_valid_i && cq_ready_o && cq_data_i.enq)
        qv_q[wslot] <= 1'b1;
      if (st_q == BkPick) ok_q <= boundary && pok;
      if (st_q == BkIssue) begin
        if (ok_q) begin
          qv_q <= {1'b0, qv_q[QueueDepth-1:1]} |
                  (qv_q & ((QueueDepth'(1) << sel_q) - QueueDepth'(1)));
          res_v_q <= 1'b1;
          chan_q <= cyc_q + time_t'(ccd_t);
          brdy_q[sb] <= cyc_q + time_t'(dly_t);
          if (cls_q != ClsHit) begin
            bcf_q[sb] <= cyc_q + time_t'(ras_t);
            open_q[sb] <= 1'b1;
          end
        end
        if ({1'b0, ph_q} + 5'd1 >= div) ph_q <= '0;
        else ph_q <= ph_q + 4'd1;
        cyc_q <= cyc_q + 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BkPick) |=> (st_q == BkIssue)) else $error("sequence broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o |=> res_v_q) else $error("issue lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o |-> qv_q[sel_q]) else $error("issued empty slot");

endmodule

// ===== design/dram_row_hit_first_scheduler.sv =====
// ----------------------------------------------------------------------------
// dram_row_hit_first_scheduler
// Single-channel DRAM scheduler, row-hit-first then oldest-first.
// ----------------------------------------------------------------------------
// An enqueue item is taken by the back end in its idle state; a tick item
// passes through the accept, pick (over the sixteen-entry queue) and issue
// and timer update steps there, and when it issues a request the next
// command waits until the result has been taken. The two-entry command
// queue lets the front end accept up to two items ahead of the back end.
// A full-queue rejection is answered from the front end once every earlier
// item is done. Configuration writes take effect at once and are always
// accepted.
module dram_row_hit_first_scheduler (
  input  logic         clk_i,
  input  logic         rst_ni,
  drhfs_in_if.sink     in_if,
  drhfs_out_if.source  out_if,
  drhfs_cfg_if.sink    cfg_if
);
  import drhfs_pkg::*;

  cfg_t      cfg_q;
  logic      cqw_valid, cqw_ready, cqr_valid, cqr_ready, dec;
  cmd_t      cqw_data, cqr_data;
  logic      rej_valid, rej_ready, rej_pre, iss_valid, iss_ready;
  logic [7:0] rej_tag;
  out_item_t iss_data, rej_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{divider: 5'd4, ccd: 8'd4, rp: 8'd14, ras: 8'd33, rcd: 8'd14, cl: 8'd14};
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CfgDivider: cfg_q.divider <= cfg_if.wdata[4:0];
        CfgCcd:     cfg_q.ccd <= cfg_if.wdata;
        CfgRp:      cfg_q.rp <= cfg_if.wdata;
        CfgRas:     cfg_q.ras <= cfg_if.wdata;
        CfgRcd:     cfg_q.rcd <= cfg_if.wdata;
        CfgCl:      cfg_q.cl <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  drhfs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .cq_ready_i(cqw_ready), .cq_valid_o(cqw_valid), .cq_data_o(cqw_data),
    .dec_i(dec), .rej_valid_o(rej_valid), .rej_tag_o(rej_tag),
    .rej_ready_i(rej_ready)
  );

  drhfs_cmdq u_cmdq (
    .clk_i, .rst_ni,
    .wr_valid_i(cqw_valid), .wr_ready_o(cqw_ready), .wr_data_i(cqw_data),
    .rd_valid_o(cqr_valid), .rd_ready_i(cqr_ready), .rd_data_o(cqr_data)
  );

  drhfs_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .cq_valid_i(cqr_valid), .cq_ready_o(cqr_ready), .cq_data_i(cqr_data),
    .dec_o(dec), .iss_valid_o(iss_valid), .iss_data_o(iss_data),
    .iss_ready_i(iss_ready)
  );

  // rejections wait until all earlier items are done to keep order
  assign rej_data = '{result_kind: KindRejected, out_tag: rej_tag, out_bank: '0,
                      out_row: '0, access_class: 2'(ClsHit), ready_cycle: '0};
  assign rej_pre   = !iss_valid && !cqr_valid && cqr_ready;
  assign rej_ready = out_if.ready && rej_pre;
  assign iss_ready = out_if.ready;
  assign out_if.valid = iss_valid || (rej_valid && rej_pre);
  assign out_if.data  = iss_valid ? iss_data : rej_data;

endmodule

// ===== tb/tb_dram_row_hit_first_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_dram_row_hit_first_scheduler
// Self-checking testbench of the row-hit-first DRAM scheduler: directed items
// for hits, misses, conflicts, queue overflow and timing register extremes,
// then random enqueue/tick traffic under several settings, all checked field
// by field against an in-bench scheduler model, with random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dram_row_hit_first_scheduler;
  import drhfs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 12;
  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 3'd7;
  localparam logic FuncTick = 1'b0;
  localparam logic FuncEnq  = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  drhfs_in_if  in_if ();
  drhfs_out_if out_if ();
  drhfs_cfg_if cfg_if ();

  dram_row_hit_first_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  always #5 clk_i = ~clk_i;

  // scheduler model state
  logic [4:0]          m_div;
  logic [7:0]          m_ccd, m_rp, m_ras, m_rcd, m_cl;
  time_t               m_now, m_chan_rdy;
  logic [3:0]          m_phase;
  logic [RowBits-1:0]  m_open_row [NumBanks];
  logic                m_open     [NumBanks];
  time_t               m_bank_rdy [NumBanks];
  time_t               m_conf_rdy [NumBanks];
  entry_t              m_queue [$];

  out_item_t pending_results [$];
  int unsigned n_items, n_results, n_cfg, n_hit, n_miss, n_conf, n_rej, errors;
  int unsigned cycles;
  bit no_idle;
  logic [RowBits-1:0] row_pool [4];

  function automatic int unsigned eff_div();
    if (m_div == 0) return 1;
    if (m_div > 16) return 16;
    return m_div;
  endfunction

  function automatic time_t later(time_t now, int unsigned clocks);
    return now + time_t'(clocks * eff_div());
  endfunction

  function automatic logic [1:0] classify(entry_t e);
    if (!m_open[e.bank]) return ClsMiss;
    if (m_open_row[e.bank] == e.row) return ClsHit;
    return ClsConflict;
  endfunction

  function automatic void sched_reset();
    m_div = 4; m_ccd = 4; m_rp = 14; m_ras = 33; m_rcd = 14; m_cl = 14;
    m_now = '0; m_chan_rdy = '0; m_phase = '0;
    for (int b = 0; b < NumBanks; b++) begin
      m_open[b] = 1'b0; m_open_row[b] = '0; m_bank_rdy[b] = '0; m_conf_rdy[b] = '0;
    end
    m_queue.delete();
  endfunction

  function automatic void sched_config(logic [CfgIdxBits-1:0] idx, logic [7:0] v);
    case (idx)
      CfgDivider: m_div = v[4:0];
      CfgCcd:     m_ccd = v;
      CfgRp:      m_rp  = v;
      CfgRas:     m_ras = v;
      CfgRcd:     m_rcd = v;
      CfgCl:      m_cl  = v;
      default: ;
    endcase
  endfunction

  // returns 1 when the item causes a result
  function automatic bit sched_step(in_item_t it, output out_item_t r);
    int best;
    entry_t e;
    logic [1:0] cls;
    int unsigned dly;
    r = '0;
    if (it.func == FuncEnq) begin
      if (m_queue.size() < QueueDepth) begin
        e.bank = it.req_bank; e.row = it.req_row; e.tag = it.req_tag;
        m_queue.push_back(e);
        return 0;
      end
      r.result_kind = KindRejected;
      r.out_tag = it.req_tag;
      return 1;
    end
    best = -1;
    if (m_phase == 0 && m_chan_rdy <= m_now) begin
      for (int i = 0; i < m_queue.size(); i++) begin
        e = m_queue[i];
        if (m_bank_rdy[e.bank] > m_now) continue;
        cls = classify(e);
        if (cls == ClsHit) begin
          best = i;
          break;
        end
        if (best < 0) begin
          if (cls == ClsConflict && m_conf_rdy[e.bank] > m_now) continue;
          best = i;
        end
      end
    end
    if (best >= 0) begin
      e = m_queue[best];
      cls = classify(e);
      r.result_kind = KindIssued;
      r.out_tag = e.tag; r.out_bank = e.bank; r.out_row = e.row; r.access_class = cls;
      m_chan_rdy = later(m_now, m_ccd);
      dly = 0;
      if (cls != ClsHit) begin
        if (cls == ClsConflict) dly += m_rp;
        m_conf_rdy[e.bank] = later(m_now, dly + m_ras);
        dly += m_rcd;
        m_open_row[e.bank] = e.row;
        m_open[e.bank] = 1'b1;
      end
      dly += m_ccd;
      m_bank_rdy[e.bank] = later(m_now, dly);
      r.ready_cycle = later(m_now, dly + m_cl);
      m_queue.delete(best);
    end
    if (m_phase + 1 >= eff_div()) m_phase = '0;
    else m_phase = m_phase + 1'b1;
    m_now = m_now + 1'b1;
    return best >= 0;
  endfunction

  // acceptance, prediction and result checking in one place, in item order
  always @(posedge clk_i) begin
    out_item_t r, got;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
      if (cfg_if.valid && cfg_if.ready) sched_config(cfg_if.index, cfg_if.wdata);
      if (in_if.valid && in_if.ready) begin
        n_items++;
        if (sched_step(in_if.data, r)) pending_results.push_back(r);
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: tag %0d", got.out_tag);
          errors++;
        end else begin
          r = pending_results.pop_front();
          if (r.result_kind == KindRejected) n_rej++;
          else if (r.access_class == ClsHit) n_hit++;
          else if (r.access_class == ClsMiss) n_miss++;
          else n_conf++;
          if (got.result_kind !== r.result_kind) begin
            $error("result_kind: expected %0d, actual %0d", r.result_kind, got.result_kind);
            errors++;
          end
          if (got.out_tag !== r.out_tag) begin
            $error("out_tag: expected %0d, actual %0d", r.out_tag, got.out_tag);
            errors++;
          end
          if (got.out_bank !== r.out_bank) begin
            $error("out_bank: expected %0d, actual %0d", r.out_bank, got.out_bank);
            errors++;
          end
          if (got.out_row !== r.out_row) begin
            $error("out_row: expected %0h, actual %0h", r.out_row, got.out_row);
            errors++;
          end
          if (got.access_class !== r.access_class) begin
            $error("access_class: expected %0d, actual %0d", r.access_class,
                   got.access_class);
            errors++;
          end
          if (got.ready_cycle !== r.ready_cycle) begin
            $error("ready_cycle: expected %0d, actual %0d", r.ready_cycle,
                   got.ready_cycle);
            errors++;
          end
        end
      end
    end
  end

  // result receiver with random stalls
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_item(logic func, logic [2:0] bank, logic [15:0] row,
                           logic [7:0] tag);
    int unsigned gap;
    in_item_t it;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.func = func; it.req_bank = bank; it.req_row = row; it.req_tag = tag;
    in_if.data  <= it;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic tick(int unsigned n);
    repeat (n) send_item(FuncTick, 3'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxBits-1:0] idx, logic [7:0] v);
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic set_timing(logic [7:0] dv, logic [7:0] ccd, logic [7:0] rp,
                            logic [7:0] ras, logic [7:0] rcd, logic [7:0] cl);
    drain();
    write_cfg(CfgDivider, dv);
    write_cfg(CfgCcd, ccd);
    write_cfg(CfgRp, rp);
    write_cfg(CfgRas, ras);
    write_cfg(CfgRcd, rcd);
    write_cfg(CfgCl, cl);
  endtask

  // enough ticks to let the queue empty under the current timing
  task automatic flush_queue();
    while (m_queue.size() != 0) tick(8);
    drain();
  endtask

  task automatic test_hit_miss_conflict();
    send_item(FuncEnq, 3'd0, 16'h0000, 8'h00);
    send_item(FuncEnq, 3'd0, 16'h0000, 8'h01);
    send_item(FuncEnq, 3'd7, 16'hffff, 8'hff);
    send_item(FuncEnq, 3'd0, 16'h1234, 8'h02);
    send_item(FuncEnq, 3'd7, 16'hffff, 8'h80);
    flush_queue();
  endtask

  task automatic test_queue_full();
    set_timing(8'd1, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1);
    for (int i = 0; i < QueueDepth + 3; i++)
      send_item(FuncEnq, i[2:0], 16'h00aa + i[15:0], i[7:0]);
    flush_queue();
  endtask

  task automatic test_timing_extremes();
    set_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    write_cfg(CfgSpareLo, 8'hff);
    write_cfg(CfgSpareHi, 8'h55);
    send_item(FuncEnq, 3'd3, 16'h0001, 8'h10);
    send_item(FuncEnq, 3'd3, 16'h0002, 8'h11);
    send_item(FuncEnq, 3'd3, 16'h0001, 8'h12);
    flush_queue();
    set_timing(8'd31, 8'd1, 8'd255, 8'd1, 8'd1, 8'd255);
    send_item(FuncEnq, 3'd5, 16'h8000, 8'h20);
    send_item(FuncEnq, 3'd6, 16'h7fff, 8'h21);
    tick(40);
    drain();
    set_timing(8'd16, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1);
    send_item(FuncEnq, 3'd2, 16'h5555, 8'h30);
    send_item(FuncEnq, 3'd2, 16'haaaa, 8'h31);
    tick(60);
    flush_queue();
  endtask

  task automatic random_phase(int unsigned n_rand);
    logic [15:0] row;
    for (int i = 0; i < n_rand; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        row = ($urandom_range(0, 9) < 8) ? row_pool[$urandom_range(0, 3)] : 16'($urandom);
        send_item(FuncEnq, 3'($urandom), row, 8'($urandom));
      end else begin
        send_item(FuncTick, 3'($urandom), 16'($urandom), 8'($urandom));
      end
      if (i == n_rand / 2) begin
        // sender holds off until every expected result has come
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  task automatic test_random();
    row_pool[0] = 16'h0000; row_pool[1] = 16'hffff;
    row_pool[2] = 16'h3c5a; row_pool[3] = 16'hc3a5;
    set_timing(8'd1, 8'd1, 8'd2, 8'd4, 8'd2, 8'd3);
    random_phase(60);
    set_timing(8'd2, 8'd2, 8'd5, 8'd9, 8'd3, 8'd1);
    no_idle = 1'b1;
    random_phase(40);
    no_idle = 1'b0;
    set_timing(8'd4, 8'd4, 8'd14, 8'd33, 8'd14, 8'd14);
    random_phase(60);
    set_timing(8'd3, 8'd0, 8'd0, 8'd7, 8'd0, 8'd255);
    random_phase(40);
    flush_queue();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    no_idle = 1'b0;
    cycles = 0;
    sched_reset();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_hit_miss_conflict();
    test_queue_full();
    test_timing_extremes();
    test_random();
    drain();
    $display("covered %0d items, %0d config writes, %0d results", n_items, n_cfg,
             n_results);
    $display("issued %0d hits, %0d misses, %0d conflicts; %0d rejected", n_hit, n_miss,
             n_conf, n_rej);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/drhfs_pkg.sv
design/drhfs_if.sv
design/drhfs_front.sv
design/drhfs_cmdq.sv
design/drhfs_back.sv
design/dram_row_hit_first_scheduler.sv
tb/tb_dram_row_hit_first_scheduler.sv
